@@ hdl/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants and types of the Bayer plane extractor: register map,
// channel codes, field widths, reset values, default frame limits and the clamp cap.
// ----------------------------------------------------------------------------
package bpe_pkg;

    // default frame limits
    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int MAX_ROWS_DEF    = 4096;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 17;
    localparam int SIZE_W   = 16;   // width used for size arithmetic
    localparam int DIM_W    = 13;
    localparam int MODE_W   = 3;
    localparam int CLAMP_W  = 6;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_WIDTH  = 2'd0;
    localparam reg_idx_t REG_HEIGHT = 2'd1;
    localparam reg_idx_t REG_MODE   = 2'd2;
    localparam reg_idx_t REG_CLAMP  = 2'd3;

    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_RED    = 3'd0;
    localparam mode_t MODE_BLUE   = 3'd1;
    localparam mode_t MODE_GREEN1 = 3'd2;
    localparam mode_t MODE_GREEN2 = 3'd3;
    localparam mode_t MODE_GAVG   = 3'd4;

    // register reset values
    localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd4096;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd4096;
    localparam mode_t              MODE_RST   = MODE_GAVG;
    localparam logic [CLAMP_W-1:0] CLAMP_RST  = 6'd16;

    // saturation limit in half units, clamp_bits of 1..16 only
    function automatic logic [VALUE_W-1:0] clamp_cap(input logic [CLAMP_W-1:0] bits);
        logic [SAMPLE_W-1:0] ones;
        ones = {SAMPLE_W{1'b1}} >> (5'(SAMPLE_W) - bits[4:0]);
        return {ones, 1'b0};
    endfunction

endpackage

@@ hdl/bayer_plane_extract.sv @@
// ----------------------------------------------------------------------------
// bayer_plane_extract
// Extracts one half-resolution plane (R, B, G1, G2 or green mean) from a
// raster stream of raw Bayer samples; results in half units, optional clamp.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction | transfer when
//  --------+-------------------------------+-----------+-------------------
//  input   | s_valid s_ready s_sample      | in        | s_valid & s_ready
//  result  | m_valid m_ready m_value_half  | out       | m_valid & m_ready
//          | m_row_end m_frame_end         |           |
//  config  | psel penable pwrite paddr ... | in        | psel&penable&pwrite
//
//  one sample per cycle sustained while the output is not stalled; a result
//  passes the read stage with the green line memory read, then the output register
//  reset clears counters and valids; the green line memory is not cleared
//  a stalled output holds the output register, then the read stage, then s_ready
// ----------------------------------------------------------------------------
module bayer_plane_extract #(
    parameter int MAX_COLUMNS = bpe_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = bpe_pkg::MAX_ROWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bpe_pkg::SAMPLE_W-1:0]  s_sample,
    // plane output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bpe_pkg::VALUE_W-1:0]   m_value_half,
    output logic                          m_row_end,
    output logic                          m_frame_end,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpe_pkg::APB_AW-1:0]    paddr,
    input  logic [bpe_pkg::APB_DW-1:0]    pwdata,
    output logic [bpe_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import bpe_pkg::*;

    localparam int CW         = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LINE_DEPTH = MAX_COLUMNS / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    mode_t              mode_reg;
    logic [CLAMP_W-1:0] clamp_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            mode_reg   <= MODE_RST;
            clamp_reg  <= CLAMP_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_MODE:   mode_reg   <= pwdata[MODE_W-1:0];
                REG_CLAMP:  clamp_reg  <= pwdata[CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            REG_MODE:   prdata = APB_DW'(mode_reg);
            REG_CLAMP:  prdata = APB_DW'(clamp_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // effective frame size
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;

    always_comb begin
        w_eff = SIZE_W'(width_reg);
        if (w_eff < SIZE_W'(2))
            w_eff = SIZE_W'(2);
        else if (w_eff > SIZE_W'(MAX_COLUMNS))
            w_eff = SIZE_W'(MAX_COLUMNS);
        h_eff = SIZE_W'(height_reg);
        if (h_eff < SIZE_W'(2))
            h_eff = SIZE_W'(2);
        else if (h_eff > SIZE_W'(MAX_ROWS))
            h_eff = SIZE_W'(MAX_ROWS);
    end

    // ------------------------------------------------------------------
    // position counters and site decode (accept stage)
    // ------------------------------------------------------------------
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [SIZE_W-1:0]  col_ext, row_ext;
    logic               in_frame;
    logic               c_odd, r_odd;
    logic               emit;
    logic               use_avg;
    logic               row_last, frame_last;
    logic               s_xfer;
    logic               line_we;
    logic [CW-1:0]      idx_full;
    logic [LINE_AW-1:0] line_addr;

    assign s_xfer   = s_valid && s_ready;
    assign col_ext  = SIZE_W'(col_reg);
    assign row_ext  = SIZE_W'(row_reg);
    assign in_frame = (col_ext < {w_eff[SIZE_W-1:1], 1'b0})
                   && (row_ext < {h_eff[SIZE_W-1:1], 1'b0});
    assign c_odd    = col_reg[0];
    assign r_odd    = row_reg[0];
    assign idx_full = col_reg >> 1;
    assign line_addr = idx_full[LINE_AW-1:0];
    assign line_we  = s_xfer && in_frame && !r_odd && !c_odd;
    assign row_last = (col_ext >> 1) == ((w_eff >> 1) - SIZE_W'(1));
    assign frame_last = row_last && ((row_ext >> 1) == ((h_eff >> 1) - SIZE_W'(1)));

    always_comb begin
        emit    = 1'b0;
        use_avg = 1'b0;
        case (mode_reg)
            MODE_RED:    emit = r_odd && !c_odd;
            MODE_BLUE:   emit = !r_odd && c_odd;
            MODE_GREEN1: emit = r_odd && c_odd;
            MODE_GREEN2: emit = !r_odd && !c_odd;
            MODE_GAVG: begin
                emit    = r_odd && c_odd;
                use_avg = 1'b1;
            end
            default:     emit = 1'b0;
        endcase
        emit = emit && in_frame;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_ext + SIZE_W'(1) >= w_eff) begin
            col_next = '0;
            row_next = (row_ext + SIZE_W'(1) >= h_eff) ? '0 : row_reg + RW'(1);
        end else begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_xfer) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // green line memory: even-row even-column sample of each cell column
    // write and read of one entry can fall in the same cycle on an even row, but the
    // green mean uses the read on the odd row below, after the write to it
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] green_line [LINE_DEPTH];
    logic [SAMPLE_W-1:0] line_rd_reg;

    always_ff @(posedge aclk) begin
        if (line_we)
            green_line[line_addr] <= s_sample;
        if (s_xfer)
            line_rd_reg <= green_line[line_addr];
    end

    // ------------------------------------------------------------------
    // read stage
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_avg_reg;
    logic                s1_row_end_reg;
    logic                s1_frame_end_reg;
    logic                s1_advance;
    logic [VALUE_W-1:0]  s1_raw;
    logic [VALUE_W-1:0]  s1_value;
    logic [VALUE_W-1:0]  cap;

    assign s1_advance = !m_valid || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_xfer && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_sample_reg    <= s_sample;
            s1_avg_reg       <= use_avg;
            s1_row_end_reg   <= row_last;
            s1_frame_end_reg <= frame_last;
        end
    end

    assign cap    = clamp_cap(clamp_reg);
    assign s1_raw = s1_avg_reg ? (VALUE_W'(line_rd_reg) + VALUE_W'(s1_sample_reg))
                               : {s1_sample_reg, 1'b0};

    always_comb begin
        s1_value = s1_raw;
        if (clamp_reg != '0 && clamp_reg < CLAMP_W'(17) && s1_raw > cap)
            s1_value = cap;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_value_reg;
    logic               m_row_end_reg;
    logic               m_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_value_reg     <= s1_value;
            m_row_end_reg   <= s1_row_end_reg;
            m_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value_half = m_value_reg;
    assign m_row_end    = m_row_end_reg;
    assign m_frame_end  = m_frame_end_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_frame_end_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_row_end)
        else $error("frame end without row end");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_ready |=> s1_valid_reg && $stable(s1_sample_reg))
        else $error("read stage lost its item under stall");

    a_counters_after_reset: assert property (@(posedge aclk)
        !aresetn |=> col_reg == '0 && row_reg == '0 && !m_valid_reg)
        else $error("counters not cleared by reset");

endmodule

@@ test/tb_bayer_plane_extract.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bayer_plane_extract
// Streams raw Bayer frames through the plane extractor and checks every plane
// value, row end and frame end against a cycle-free model of the cell logic.
// Covers every channel mode, tiny, odd and oversized frames, clamping,
// mid-frame register changes and random handshake stalls on both sides.
// ----------------------------------------------------------------------------
module tb_bayer_plane_extract;
    import bpe_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int SETTLE       = 8;     // pipeline depth plus margin
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_FROM    = 1500;  // no stalls after this many items
    localparam int LINE_DEPTH   = MAX_COLUMNS_DEF / 2;

    localparam mode_t MODE_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value_half;
        logic               row_end;
        logic               frame_end;
    } plane_result_t;

    // cell model of the extractor plus the queue of plane values still owed
    class plane_scoreboard;
        logic [DIM_W-1:0]    width_reg;
        logic [DIM_W-1:0]    height_reg;
        mode_t               mode_reg;
        logic [CLAMP_W-1:0]  clamp_reg;
        int unsigned         col_pos;
        int unsigned         row_pos;
        logic [SAMPLE_W-1:0] green_line [LINE_DEPTH];
        plane_result_t       pending_values [$];
        int unsigned         mismatches;

        function new();
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            mode_reg   = MODE_RST;
            clamp_reg  = CLAMP_RST;
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
            foreach (green_line[i]) green_line[i] = '0;
        endfunction

        function int unsigned clip_dim(int unsigned v, int unsigned lim);
            if (v < 2) return 2;
            if (v > lim) return lim;
            return v;
        endfunction

        function int unsigned frame_len();
            return clip_dim(32'(width_reg), MAX_COLUMNS_DEF)
                 * clip_dim(32'(height_reg), MAX_ROWS_DEF);
        endfunction

        function int unsigned pending();
            return pending_values.size();
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] data);
            case (idx)
                REG_WIDTH:  width_reg  = data[DIM_W-1:0];
                REG_HEIGHT: height_reg = data[DIM_W-1:0];
                REG_MODE:   mode_reg   = data[MODE_W-1:0];
                REG_CLAMP:  clamp_reg  = data[CLAMP_W-1:0];
                default:    ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] smp);
            int unsigned   w, h, pw, ph, c, r, idx, sum, cap;
            bit            in_frame, c_odd, r_odd, emit;
            plane_result_t res;
            w        = clip_dim(32'(width_reg), MAX_COLUMNS_DEF);
            h        = clip_dim(32'(height_reg), MAX_ROWS_DEF);
            pw       = w / 2;
            ph       = h / 2;
            c        = col_pos;
            r        = row_pos;
            c_odd    = c[0];
            r_odd    = r[0];
            in_frame = (c < pw * 2) && (r < ph * 2);
            emit     = 1'b0;
            sum      = 0;
            if (in_frame) begin
                idx = c / 2;
                if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
                // the even/even green is kept in every mode
                if (!r_odd && !c_odd) green_line[idx] = smp;
                case (mode_reg)
                    MODE_RED: begin
                        emit = r_odd && !c_odd;
                        sum  = 2 * int'(smp);
                    end
                    MODE_BLUE: begin
                        emit = !r_odd && c_odd;
                        sum  = 2 * int'(smp);
                    end
                    MODE_GREEN1: begin
                        emit = r_odd && c_odd;
                        sum  = 2 * int'(smp);
                    end
                    MODE_GREEN2: begin
                        emit = !r_odd && !c_odd;
                        sum  = 2 * int'(smp);
                    end
                    MODE_GAVG: begin
                        emit = r_odd && c_odd;
                        sum  = int'(green_line[idx]) + int'(smp);
                    end
                    default: emit = 1'b0;
                endcase
            end
            if (emit) begin
                if (clamp_reg != 0 && clamp_reg < 17) begin
                    cap = ((1 << clamp_reg) - 1) * 2;
                    if (sum > cap) sum = cap;
                end
                res.value_half = VALUE_W'(sum);
                res.row_end    = (c / 2) == pw - 1;
                res.frame_end  = res.row_end && ((r / 2) == ph - 1);
                pending_values.push_back(res);
            end
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void check_result(logic [VALUE_W-1:0] value, logic row_end, logic frame_end);
            plane_result_t want;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected plane value %0d (row_end %0b frame_end %0b)",
                         $time, value, row_end, frame_end);
                mismatches++;
                return;
            end
            want = pending_values.pop_front();
            if (value !== want.value_half) begin
                $display("%0t: value_half expected %0d, got %0d", $time, want.value_half, value);
                mismatches++;
            end
            if (row_end !== want.row_end) begin
                $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, row_end);
                mismatches++;
            end
            if (frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                         frame_end);
                mismatches++;
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [VALUE_W-1:0]  m_value_half;
    logic                m_row_end;
    logic                m_frame_end;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    plane_scoreboard plane_sb = new();
    bit              jitter_on     = 1'b1;
    bit              long_hold_req = 1'b0;
    int unsigned     quiet_cycles  = 0;

    bayer_plane_extract u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_half (m_value_half),
        .m_row_end    (m_row_end),
        .m_frame_end  (m_frame_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // result side: short random stalls, plus one long hold on request
    initial begin : result_sink
        int unsigned hold;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (jitter_on && $urandom_range(0, 11) == 0) begin
                hold = $urandom_range(1, 15);
            end else begin
                hold = 0;
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            plane_sb.check_result(m_value_half, m_row_end, m_frame_end);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_xfer(input bit wr, input reg_idx_t idx, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== want) begin
            $display("%0t: register %0d expected %h, got %h", $time, idx, want, rd);
            plane_sb.mismatches++;
        end
    endtask

    // junk above the register width must be ignored
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] mask, data, rd;
        case (idx)
            REG_MODE:  mask = (32'd1 << MODE_W) - 1;
            REG_CLAMP: mask = (32'd1 << CLAMP_W) - 1;
            default:   mask = (32'd1 << DIM_W) - 1;
        endcase
        data = (value & mask) | ($urandom() & ~mask);
        apb_xfer(1'b1, idx, data, rd);
        plane_sb.set_reg(idx, data);
        check_reg(idx, data & mask);
    endtask

    task automatic drain_plane();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (plane_sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_plane(input logic [DIM_W-1:0] wid, input logic [DIM_W-1:0] hgt,
                             input mode_t mode, input logic [CLAMP_W-1:0] clamp);
        drain_plane();
        write_reg(REG_WIDTH, 32'(wid));
        write_reg(REG_HEIGHT, 32'(hgt));
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_CLAMP, 32'(clamp));
    endtask

    // valid is only lowered for a gap, never between back-to-back transfers
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        if (jitter_on && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        plane_sb.note_sample(smp);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        logic [DIM_W-1:0]   wid, hgt;
        mode_t              mode;
        logic [CLAMP_W-1:0] clamp;
        int unsigned        n, random_count, phase_no;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        check_reg(REG_WIDTH, 32'(WIDTH_RST));
        check_reg(REG_HEIGHT, 32'(HEIGHT_RST));
        check_reg(REG_MODE, 32'(MODE_RST));
        check_reg(REG_CLAMP, 32'(CLAMP_RST));

        // green mean, no clamp: largest possible sum, then a tiny one
        set_plane(4, 2, MODE_GAVG, 0);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'h0000);
        push_sample(16'h7FFF);
        push_sample(16'h1234);
        push_sample(16'hFFFF);
        push_sample(16'h8000);
        push_sample(16'h0001);

        // green one with an 8 bit clamp, then green two mid frame, then the
        // height shrinks under the current row so the frame closes at once
        set_plane(2, 4, MODE_GREEN1, 8);
        push_sample(16'h0FFF);
        push_sample(16'h00AA);
        push_sample(16'h0055);
        push_sample(16'h1234);
        drain_plane();
        write_reg(REG_MODE, 32'(MODE_GREEN2));
        write_reg(REG_CLAMP, 16);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        drain_plane();
        write_reg(REG_HEIGHT, 1);
        push_sample(16'h4321);
        push_sample(16'h2468);

        // blue with a large clamp, then width cut to the minimum mid row,
        // then red clamped to one bit
        set_plane(4, 2, MODE_BLUE, 17);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        push_sample(16'h8000);
        drain_plane();
        write_reg(REG_WIDTH, 0);
        write_reg(REG_MODE, 32'(MODE_RED));
        write_reg(REG_CLAMP, 1);
        push_sample(16'h3333);
        push_sample(16'hFFFF);
        push_sample(16'h5555);

        // unused mode code: counters move, nothing comes out
        set_plane(2, 2, MODE_UNKNOWN, 16);
        push_sample(16'hAAAA);
        push_sample(16'h5555);
        push_sample(16'hFFFF);
        push_sample(16'h0000);

        // oversized frames, one each way, closed early by shrinking the size
        set_plane(13'd8191, 2, MODE_GAVG, 12);
        repeat (64) push_sample(random_sample());
        drain_plane();
        write_reg(REG_WIDTH, 64);
        repeat (65) push_sample(random_sample());
        set_plane(2, 13'd5000, MODE_RED, 0);
        repeat (80) push_sample(random_sample());
        drain_plane();
        write_reg(REG_HEIGHT, 40);
        repeat (2) push_sample(random_sample());

        random_count = 0;
        phase_no     = 0;
        while (random_count < RANDOM_ITEMS) begin
            if (random_count >= CALM_FROM) jitter_on = 1'b0;
            if (phase_no == 2) begin
                // enough results to back the pipeline up during the hold
                wid   = 20;
                hgt   = 8;
                mode  = MODE_GREEN2;
                clamp = 16;
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    wid = DIM_W'($urandom_range(41, 200));
                    hgt = DIM_W'($urandom_range(2, 4));
                end else begin
                    wid = DIM_W'($urandom_range(2, 24));
                    hgt = DIM_W'($urandom_range(2, 10));
                end
                mode = mode_t'($urandom_range(MODE_RED, MODE_GAVG));
                case ($urandom_range(0, 3))
                    0:       clamp = 0;
                    1:       clamp = CLAMP_W'($urandom_range(17, 63));
                    default: clamp = CLAMP_W'($urandom_range(1, 16));
                endcase
            end
            set_plane(wid, hgt, mode, clamp);
            if (phase_no == 2) long_hold_req = 1'b1;
            n = plane_sb.frame_len() * $urandom_range(1, 3);
            repeat (n) begin
                push_sample(random_sample());
                random_count++;
            end
            phase_no++;
        end

        drain_plane();
        if (plane_sb.mismatches == 0 && plane_sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
